/* src/tia_pkg.sv */
// ----------------------------------------------------------------------------
// tia_pkg: shared types and constants for the transaction id allocator
// Command and status codes, the result record and the stack control bundle.
// ----------------------------------------------------------------------------
package tia_pkg;

    // Default number of identifiers handed out
    localparam int unsigned MAX_IDS_DEF = 64;

    // Fixed field widths
    localparam int unsigned ID_W  = 8;
    localparam int unsigned CNT_W = 9;

    // Command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_NO_FREE        = 2'd1,
        ST_OUT_OF_RANGE   = 2'd2,
        ST_DOUBLE_RELEASE = 2'd3
    } t_status;

    // One result record
    typedef struct packed {
        logic [ID_W-1:0]  granted_id;
        t_status          status;
        logic [CNT_W-1:0] active_count;
        logic [CNT_W-1:0] updater_count;
    } t_result;

    // Stack update request: pop, push and the identifier to push
    typedef struct packed {
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } t_stk_ctrl;

endpackage

/* src/tia_stack.sv */
// ----------------------------------------------------------------------------
// tia_stack: LIFO free stack of identifiers
// Top entry and the entry below it live in registers; the rest sits in a
// memory with a registered read. Entries never disturbed since reset are
// recognized by a low-water mark and read as their position.
// ----------------------------------------------------------------------------
module tia_stack #(
    parameter int unsigned MAX_IDS = tia_pkg::MAX_IDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tia_pkg::t_stk_ctrl            i_ctrl,
    output logic [$clog2(MAX_IDS+1)-1:0]  o_depth,
    output logic [tia_pkg::ID_W-1:0]      o_top
);

    localparam int unsigned DW = $clog2(MAX_IDS + 1);
    localparam int unsigned AW = $clog2(MAX_IDS);
    localparam int unsigned IW = tia_pkg::ID_W;

    logic [DW-1:0] r_depth;
    logic [DW-1:0] r_low;
    logic [IW-1:0] r_top;
    logic [IW-1:0] r_nxt_reg;
    logic          r_nxt_mem;
    logic          r_rd_init;
    logic [IW-1:0] r_rd_pos;
    logic [IW-1:0] r_rdata;
    logic [IW-1:0] mem [MAX_IDS];

    logic [IW-1:0] w_nxt;
    logic [DW-1:0] w_dec;
    logic [DW-1:0] w_rd_pos;
    logic [DW-1:0] w_wr_pos;

    // Entry below the top: from the memory read or from the holding register
    assign w_nxt    = r_nxt_mem ? (r_rd_init ? r_rd_pos : r_rdata) : r_nxt_reg;
    assign w_dec    = r_depth - DW'(1);
    assign w_rd_pos = r_depth - DW'(3);
    assign w_wr_pos = r_depth - DW'(1);

    // Memory: write the old top on push, prefetch the entry below the new top on pop
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && r_depth != '0) begin
            mem[w_wr_pos[AW-1:0]] <= r_top;
        end
        if (i_ctrl.pop) begin
            r_rdata <= mem[w_rd_pos[AW-1:0]];
        end
    end

    // Stack pointer, cached entries and low-water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= DW'(MAX_IDS);
            r_low     <= DW'(MAX_IDS);
            r_top     <= IW'(MAX_IDS - 1);
            r_nxt_reg <= IW'(MAX_IDS - 2);
            r_nxt_mem <= 1'b0;
            r_rd_init <= 1'b0;
            r_rd_pos  <= '0;
        end else if (i_ctrl.pop) begin
            r_depth   <= w_dec;
            r_top     <= w_nxt;
            r_nxt_mem <= 1'b1;
            r_rd_init <= (w_rd_pos < r_low);
            r_rd_pos  <= IW'(w_rd_pos);
            if (w_dec < r_low) begin
                r_low <= w_dec;
            end
        end else if (i_ctrl.push) begin
            r_depth   <= r_depth + DW'(1);
            r_top     <= i_ctrl.push_id;
            r_nxt_reg <= r_top;
            r_nxt_mem <= 1'b0;
        end
    end

    assign o_depth = r_depth;
    assign o_top   = r_top;

endmodule

/* src/transaction_id_allocator.sv */
// ----------------------------------------------------------------------------
// transaction_id_allocator: LIFO free-list identifier allocator
// Grants and takes back identifiers, tracks active and updater counts.
// ----------------------------------------------------------------------------
// One transfer is taken every cycle and its result appears in the output
// register on the next cycle; a second output entry absorbs one stalled
// result, so the input stalls only when both output entries are full. The
// figure is set by the stack update: the top of the stack and
// the entry below it are held in registers while deeper entries come from a
// memory with a registered read, prefetched on every grant. Identifiers
// MAX_IDS-1 down to 0 are granted in that order after reset, without any
// clearing pass. A release of an identifier at or above MAX_IDS reports
// out-of-range, and a release of an identifier that is already free reports
// a double release; neither changes any state. The read-only count
// saturates at MAX_IDS and at zero, and the updater count reads zero when
// the read-only count exceeds the active count.
// ----------------------------------------------------------------------------
module transaction_id_allocator #(
    parameter int unsigned MAX_IDS = tia_pkg::MAX_IDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_command,
    input  logic                       i_read_only,
    input  logic [tia_pkg::ID_W-1:0]   i_release_id,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [tia_pkg::ID_W-1:0]   o_granted_id,
    output logic [1:0]                 o_status,
    output logic [tia_pkg::CNT_W-1:0]  o_active_count,
    output logic [tia_pkg::CNT_W-1:0]  o_updater_count
);

    localparam int unsigned DW = $clog2(MAX_IDS + 1);
    localparam int unsigned AW = $clog2(MAX_IDS);
    localparam int unsigned IW = tia_pkg::ID_W;
    localparam int unsigned CW = tia_pkg::CNT_W;

    logic [MAX_IDS-1:0] r_is_free;
    logic [DW-1:0]      r_ro_count;
    logic               r_out_valid;
    logic               r_skid_valid;
    tia_pkg::t_result   r_out;
    tia_pkg::t_result   r_skid;

    tia_pkg::t_stk_ctrl w_ctrl;
    tia_pkg::t_result   w_res;
    logic [DW-1:0]      w_depth;
    logic [IW-1:0]      w_top;
    logic               w_accept;
    logic               w_out_take;
    logic [DW-1:0]      n_depth;
    logic [DW-1:0]      n_ro_count;
    logic [CW-1:0]      w_active;
    logic [CW-1:0]      w_ro_ext;

    tia_stack #(
        .MAX_IDS (MAX_IDS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_depth (w_depth),
        .o_top   (w_top)
    );

    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_out_take = r_out_valid && !i_out_stall;

    // Decode the command against the stack and the free bits
    always_comb begin
        w_ctrl         = '0;
        w_res          = '0;
        w_res.status   = tia_pkg::ST_OK;
        n_ro_count     = r_ro_count;
        if (i_command == tia_pkg::CMD_ALLOC) begin
            if (w_depth == '0) begin
                w_res.status = tia_pkg::ST_NO_FREE;
            end else begin
                w_ctrl.pop       = w_accept;
                w_res.granted_id = w_top;
                if (i_read_only && r_ro_count < DW'(MAX_IDS)) begin
                    n_ro_count = r_ro_count + DW'(1);
                end
            end
        end else begin
            if ((CW)'(i_release_id) >= (CW)'(MAX_IDS)) begin
                w_res.status = tia_pkg::ST_OUT_OF_RANGE;
            end else if (r_is_free[i_release_id[AW-1:0]] || w_depth >= DW'(MAX_IDS)) begin
                w_res.status = tia_pkg::ST_DOUBLE_RELEASE;
            end else begin
                w_ctrl.push    = w_accept;
                w_ctrl.push_id = i_release_id;
                if (i_read_only && r_ro_count != '0) begin
                    n_ro_count = r_ro_count - DW'(1);
                end
            end
        end
        n_depth  = w_depth - DW'(w_ctrl.pop) + DW'(w_ctrl.push);
        w_active = CW'(MAX_IDS) - CW'(n_depth);
        w_ro_ext = CW'(n_ro_count);
        w_res.active_count  = w_active;
        w_res.updater_count = (w_active >= w_ro_ext) ? (w_active - w_ro_ext) : '0;
    end

    // Free bits and read-only count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_free  <= '1;
            r_ro_count <= '0;
        end else if (w_accept) begin
            r_ro_count <= n_ro_count;
            if (w_ctrl.pop) begin
                r_is_free[w_top[AW-1:0]] <= 1'b0;
            end
            if (w_ctrl.push) begin
                r_is_free[i_release_id[AW-1:0]] <= 1'b1;
            end
        end
    end

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_res;
            end
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_granted_id    = r_out.granted_id;
    assign o_status        = r_out.status;
    assign o_active_count  = r_out.active_count;
    assign o_updater_count = r_out.updater_count;

    // The skid entry only fills behind a held output entry
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // The number of identifiers marked free equals the stack depth
    a_free_matches_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_is_free) == int'(w_depth))
        else $error("free bit count differs from stack depth");

    // A granted identifier is no longer free
    a_grant_clears_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctrl.pop) |=> !r_is_free[$past(w_top[AW-1:0])])
        else $error("granted identifier still marked free");

    // Stack depth stays within the identifier range
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_depth <= DW'(MAX_IDS))
        else $error("stack depth above identifier count");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for transaction_id_allocator
// Drives allocate and release commands through the valid/stall input channel,
// predicts every result with an internal copy of the free stack, the free
// bits and the read-only count, and compares each output transfer field by
// field. Both channels idle and stall at random, with one long receiver
// hold-off and two full drains of the outstanding results.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned ID_W        = tia_pkg::ID_W;
    localparam int unsigned CNT_W       = tia_pkg::CNT_W;
    localparam int unsigned ID_COUNT    = tia_pkg::MAX_IDS_DEF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_command;
    logic                 i_read_only;
    logic [ID_W-1:0]      i_release_id;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [ID_W-1:0]      o_granted_id;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_active_count;
    logic [CNT_W-1:0]     o_updater_count;

    // Shadow copy of the allocator state
    logic [ID_W-1:0]      id_stack [ID_COUNT];
    int                   free_top;
    bit                   id_free [ID_COUNT];
    int                   ro_count;

    // Results owed by the block, oldest first
    tia_pkg::t_result     owed_results [$];

    int                   error_count;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    bit                   hold_req;
    int                   hold_left;

    transaction_id_allocator #(
        .MAX_IDS(ID_COUNT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_read_only    (i_read_only),
        .i_release_id   (i_release_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted_id   (o_granted_id),
        .o_status       (o_status),
        .o_active_count (o_active_count),
        .o_updater_count(o_updater_count)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one command to the shadow state and return the result it owes
    function automatic tia_pkg::t_result next_alloc_result(logic cmd, logic ro,
                                                           logic [ID_W-1:0] rid);
        tia_pkg::t_result r;
        int               active;
        r.granted_id = '0;
        r.status     = tia_pkg::ST_OK;
        if (cmd == tia_pkg::CMD_ALLOC) begin
            if (free_top == 0) begin
                r.status = tia_pkg::ST_NO_FREE;
            end else begin
                free_top--;
                r.granted_id = id_stack[free_top];
                id_free[r.granted_id] = 1'b0;
                if (ro && ro_count < ID_COUNT) ro_count++;
            end
        end else if (rid >= ID_COUNT) begin
            r.status = tia_pkg::ST_OUT_OF_RANGE;
        end else if (id_free[rid] || free_top >= ID_COUNT) begin
            r.status = tia_pkg::ST_DOUBLE_RELEASE;
        end else begin
            id_stack[free_top] = rid;
            free_top++;
            id_free[rid] = 1'b1;
            if (ro && ro_count > 0) ro_count--;
        end
        active          = ID_COUNT - free_top;
        r.active_count  = CNT_W'(active);
        r.updater_count = (active >= ro_count) ? CNT_W'(active - ro_count) : '0;
        return r;
    endfunction

    // Pick an identifier that is currently handed out, or any value if none is
    function automatic logic [ID_W-1:0] pick_busy_id();
        int busy [$];
        for (int i = 0; i < ID_COUNT; i++) begin
            if (!id_free[i]) busy = {busy, i};
        end
        if (busy.size() == 0) return ID_W'($urandom_range(255));
        return ID_W'(busy[$urandom_range(busy.size() - 1)]);
    endfunction

    // Check each output transfer, then predict each input transfer
    always @(posedge i_clk) begin
        tia_pkg::t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: granted_id %0d status %0d",
                           o_granted_id, o_status);
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_granted_id !== want.granted_id) begin
                        $error("granted_id expected %0d actual %0d",
                               want.granted_id, o_granted_id);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_active_count !== want.active_count) begin
                        $error("active_count expected %0d actual %0d",
                               want.active_count, o_active_count);
                        error_count++;
                    end
                    if (o_updater_count !== want.updater_count) begin
                        $error("updater_count expected %0d actual %0d",
                               want.updater_count, o_updater_count);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                owed_results = {owed_results,
                                next_alloc_result(i_command, i_read_only, i_release_id)};
            end
        end
    end

    // Receiver: random stall, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Send one command; called at a falling edge, returns at a falling edge
    task automatic send_cmd(logic cmd, logic ro, logic [ID_W-1:0] rid);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_read_only  <= ro;
        i_release_id <= rid;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hand-picked corner cases
    task automatic test_directed();
        send_cmd(tia_pkg::CMD_ALLOC,   1'b0, 8'd0);
        send_cmd(tia_pkg::CMD_ALLOC,   1'b1, 8'd255);
        send_cmd(tia_pkg::CMD_RELEASE, 1'b1, ID_W'(ID_COUNT - 2));
        send_cmd(tia_pkg::CMD_RELEASE, 1'b1, ID_W'(ID_COUNT - 2));
        send_cmd(tia_pkg::CMD_RELEASE, 1'b0, ID_W'(ID_COUNT));
        send_cmd(tia_pkg::CMD_RELEASE, 1'b1, 8'd255);
        send_cmd(tia_pkg::CMD_RELEASE, 1'b0, 8'd0);
        // read-only release while the read-only count is zero
        send_cmd(tia_pkg::CMD_RELEASE, 1'b1, ID_W'(ID_COUNT - 1));
        // more read-only holders than active ids
        send_cmd(tia_pkg::CMD_ALLOC,   1'b1, 8'd0);
        send_cmd(tia_pkg::CMD_ALLOC,   1'b1, 8'd0);
        send_cmd(tia_pkg::CMD_RELEASE, 1'b0, ID_W'(ID_COUNT - 1));
        send_cmd(tia_pkg::CMD_RELEASE, 1'b0, ID_W'(ID_COUNT - 2));
        send_cmd(tia_pkg::CMD_ALLOC,   1'b0, 8'd170);
        send_cmd(tia_pkg::CMD_ALLOC,   1'b0, 8'd85);
        send_cmd(tia_pkg::CMD_RELEASE, 1'b1, ID_W'(ID_COUNT - 2));
        send_cmd(tia_pkg::CMD_RELEASE, 1'b1, ID_W'(ID_COUNT - 1));
        send_cmd(tia_pkg::CMD_RELEASE, 1'b1, ID_W'(ID_COUNT - 1));
        send_cmd(tia_pkg::CMD_RELEASE, 1'b0, 8'd128);
    endtask

    // Empty the free stack, allocate past empty, then give everything back
    task automatic test_exhaust();
        repeat (ID_COUNT + 2) begin
            send_cmd(tia_pkg::CMD_ALLOC, 1'($urandom_range(1)), ID_W'($urandom_range(255)));
        end
        while (free_top < ID_COUNT) send_cmd(tia_pkg::CMD_RELEASE, 1'b0, pick_busy_id());
    endtask

    // Drive the read-only count into saturation and back to zero
    task automatic test_readonly_saturation();
        repeat (ID_COUNT + 1) send_cmd(tia_pkg::CMD_ALLOC, 1'b1, 8'd0);
        while (free_top < ID_COUNT) send_cmd(tia_pkg::CMD_RELEASE, 1'b0, pick_busy_id());
        repeat (ID_COUNT) send_cmd(tia_pkg::CMD_ALLOC, 1'b1, 8'd0);
        while (free_top < ID_COUNT) send_cmd(tia_pkg::CMD_RELEASE, 1'b1, pick_busy_id());
    endtask

    // Mostly legal allocate/release traffic with some bad releases mixed in
    task automatic test_mixed(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_cmd(tia_pkg::CMD_ALLOC, 1'($urandom_range(1)),
                         ID_W'($urandom_range(255)));
            else if (pick < 85)
                send_cmd(tia_pkg::CMD_RELEASE, 1'($urandom_range(1)), pick_busy_id());
            else if (pick < 93)
                send_cmd(tia_pkg::CMD_RELEASE, 1'($urandom_range(1)),
                         ID_W'($urandom_range(255)));
            else
                send_cmd(tia_pkg::CMD_RELEASE, 1'($urandom_range(1)),
                         ID_W'($urandom_range(ID_COUNT - 1)));
        end
    endtask

    // Hold the receiver off while commands keep coming, so the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_mixed(40);
    endtask

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        hold_req      = 1'b0;
        hold_left     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        free_top      = ID_COUNT;
        ro_count      = 0;
        for (int i = 0; i < ID_COUNT; i++) begin
            id_stack[i] = ID_W'(i);
            id_free[i]  = 1'b1;
        end
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = tia_pkg::CMD_ALLOC;
        i_read_only  = 1'b0;
        i_release_id = '0;
        i_out_stall  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 68;
        test_directed();
        test_exhaust();
        test_mixed(130);
        test_backpressure();

        send_idle_pct = 68;
        recv_idle_pct = 11;
        test_readonly_saturation();
        test_mixed(200);
        drain_results();
        test_mixed(20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_exhaust();
        test_mixed(125);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
